FILE: design/cs_pkg.sv
// Shared widths, limits and types for the cosine similarity block.
`default_nettype none
package cs_pkg;

   // Element and accumulator widths
   localparam int ELEM_W     = 16;
   localparam int DOT_W      = 42;
   localparam int NORM_W     = 41;
   localparam int DPROD_W    = 2 * ELEM_W;
   localparam int SQ_W       = 2 * ELEM_W - 1;

   // Job queue between the accumulate front and the normalize back
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   // Back-end arithmetic
   localparam int HALF_LO_W  = 21;
   localparam int HALF_HI_W  = NORM_W - HALF_LO_W;
   localparam int PP_W       = 2 * HALF_LO_W;
   localparam int PROD_W     = 84;
   localparam int ROOT_W     = 42;
   localparam int REM_W      = 45;
   localparam int FRAC_W     = 15;
   localparam int NUM_W      = DOT_W + FRAC_W;
   localparam int QUO_W      = 17;
   localparam int OUT_W      = 16;
   localparam int STEP_W     = 6;
   localparam int MUL_STEPS  = 4;
   localparam int SQRT_STEPS = PROD_W / 2;
   localparam int DIV_STEPS  = NUM_W;

   localparam logic [OUT_W-1:0] SIM_MAX = 16'h7FFF;
   localparam logic [OUT_W-1:0] SIM_MIN = 16'h8000;

   // One finished vector handed from front to back
   typedef struct packed {
      logic [DOT_W-1:0]  dot;
      logic [NORM_W-1:0] left_norm;
      logic [NORM_W-1:0] right_norm;
      logic              mismatch;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_stat_type;

endpackage
`default_nettype wire

FILE: design/cosine_similarity_top.sv
// Top level of the streaming cosine similarity block.
//
// Element pairs are accepted one per clock while req_full is low; the
// multiply-accumulate front never stalls on the arithmetic, only when the
// four-entry job queue (counting a finished vector still in the multiply
// stage) is full. Each vector marked by req_last is normalized by a
// sequential back end: it loads the job, builds the norm product from four
// 21x21 partial products, takes the bit-pair floor square root, runs the
// restoring divide and retires into the result register (degenerate vectors
// go straight to retire). Vectors shorter than the back-end time therefore
// run at the back end's pace once the queue fills; longer vectors run at one
// pair per cycle while results are popped. The result stays on
// rsp_similarity/rsp_degenerate while rsp_empty is low until popped.
`default_nettype none
module cosine_similarity_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic signed [cs_pkg::ELEM_W-1:0] req_left_value,
   input  wire logic signed [cs_pkg::ELEM_W-1:0] req_right_value,
   input  wire logic                             req_last,
   input  wire logic                             req_mismatch,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic signed [cs_pkg::OUT_W-1:0]       rsp_similarity,
   output logic                                  rsp_degenerate
);

   logic                  job_push;
   logic                  job_pop;
   cs_pkg::job_type       job_in;
   cs_pkg::job_type       job_head;
   cs_pkg::q_stat_type    q_stat;

   // Accumulate front
   cs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_left_value  (req_left_value),
      .req_right_value (req_right_value),
      .req_last        (req_last),
      .req_mismatch    (req_mismatch),
      .q_stat          (q_stat),
      .job_push        (job_push),
      .job             (job_in)
   );

   // Job queue
   cs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (job_push),
      .push_data (job_in),
      .pop_in    (job_pop),
      .head      (job_head),
      .stat      (q_stat)
   );

   // Normalize back
   cs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .job            (job_head),
      .job_pop        (job_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_similarity (rsp_similarity),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
`default_nettype wire

FILE: design/cs_front.sv
// Front end: accepts element pairs, multiplies and accumulates, hands off finished vectors.
`default_nettype none
module cs_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic signed [cs_pkg::ELEM_W-1:0] req_left_value,
   input  wire logic signed [cs_pkg::ELEM_W-1:0] req_right_value,
   input  wire logic                            req_last,
   input  wire logic                            req_mismatch,
   input  wire cs_pkg::q_stat_type              q_stat,
   output logic                                 job_push,
   output cs_pkg::job_type                      job
);

   logic                                accept;
   logic                                pend_last;
   logic signed [cs_pkg::DPROD_W-1:0]   dprod;
   logic signed [cs_pkg::DPROD_W-1:0]   lsq;
   logic signed [cs_pkg::DPROD_W-1:0]   rsq;

   logic                                vld_ff;
   logic                                last_ff;
   logic                                mism_ff;
   logic signed [cs_pkg::DPROD_W-1:0]   dprod_ff;
   logic [cs_pkg::SQ_W-1:0]             lsq_ff;
   logic [cs_pkg::SQ_W-1:0]             rsq_ff;

   logic [cs_pkg::DOT_W-1:0]            dot_ff, dot_in;
   logic [cs_pkg::NORM_W-1:0]           lnorm_ff, lnorm_in;
   logic [cs_pkg::NORM_W-1:0]           rnorm_ff, rnorm_in;
   logic                                mseen_ff, mseen_in;

   logic [cs_pkg::DOT_W-1:0]            dot_sum;
   logic [cs_pkg::NORM_W-1:0]           lnorm_sum;
   logic [cs_pkg::NORM_W-1:0]           rnorm_sum;
   logic                                mseen_sum;

   // Back-pressure: count a last item still in the multiply stage as taken
   assign pend_last = vld_ff & last_ff;
   assign req_full  = ({1'b0, q_stat.count} + (cs_pkg::QCNT_W + 1)'(pend_last)) >=
                      (cs_pkg::QCNT_W + 1)'(cs_pkg::QDEPTH);
   assign accept    = req_push & ~req_full;

   // Multiply stage
   assign dprod = req_left_value * req_right_value;
   assign lsq   = req_left_value * req_left_value;
   assign rsq   = req_right_value * req_right_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= accept;
      end
      if (accept) begin
         dprod_ff <= dprod;
         lsq_ff   <= lsq[cs_pkg::SQ_W-1:0];
         rsq_ff   <= rsq[cs_pkg::SQ_W-1:0];
         last_ff  <= req_last;
         mism_ff  <= req_mismatch;
      end
   end

   // Accumulate stage; sums wrap at their widths
   always_comb begin
      dot_sum   = dot_ff + {{(cs_pkg::DOT_W - cs_pkg::DPROD_W){dprod_ff[cs_pkg::DPROD_W-1]}},
                            dprod_ff};
      lnorm_sum = lnorm_ff + {{(cs_pkg::NORM_W - cs_pkg::SQ_W){1'b0}}, lsq_ff};
      rnorm_sum = rnorm_ff + {{(cs_pkg::NORM_W - cs_pkg::SQ_W){1'b0}}, rsq_ff};
      mseen_sum = mseen_ff | mism_ff;

      dot_in   = dot_ff;
      lnorm_in = lnorm_ff;
      rnorm_in = rnorm_ff;
      mseen_in = mseen_ff;
      job_push = 1'b0;
      job.dot        = dot_sum;
      job.left_norm  = lnorm_sum;
      job.right_norm = rnorm_sum;
      job.mismatch   = mseen_sum;

      if (vld_ff) begin
         if (last_ff) begin
            job_push = 1'b1;
            dot_in   = '0;
            lnorm_in = '0;
            rnorm_in = '0;
            mseen_in = 1'b0;
         end else begin
            dot_in   = dot_sum;
            lnorm_in = lnorm_sum;
            rnorm_in = rnorm_sum;
            mseen_in = mseen_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= '0;
         lnorm_ff <= '0;
         rnorm_ff <= '0;
         mseen_ff <= 1'b0;
      end else begin
         dot_ff   <= dot_in;
         lnorm_ff <= lnorm_in;
         rnorm_ff <= rnorm_in;
         mseen_ff <= mseen_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/cs_queue.sv
// Short job queue that decouples the accumulate front from the normalize back.
`default_nettype none
module cs_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_in,
   input  wire cs_pkg::job_type    push_data,
   input  wire logic               pop_in,
   output cs_pkg::job_type         head,
   output cs_pkg::q_stat_type      stat
);

   cs_pkg::job_type                entry_ff [cs_pkg::QDEPTH];
   logic [cs_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [cs_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [cs_pkg::QCNT_W-1:0]      count_ff;
   logic                           do_pop;

   assign do_pop     = pop_in & (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;

   // Storage
   always_ff @(posedge clock) begin
      if (push_in) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_in) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_in && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push_in && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_in && !do_pop && count_ff == cs_pkg::QCNT_W'(cs_pkg::QDEPTH)))
      else $error("job queue written while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cs_pkg::QCNT_W'(cs_pkg::QDEPTH))
      else $error("job queue count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: design/cs_back.sv
// Back end: floor root of the norm product, signed divide, saturation and result register.
`default_nettype none
module cs_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cs_pkg::q_stat_type           q_stat,
   input  wire cs_pkg::job_type              job,
   output logic                              job_pop,
   input  wire logic                         rsp_pop,
   output logic                              rsp_empty,
   output logic signed [cs_pkg::OUT_W-1:0]   rsp_similarity,
   output logic                              rsp_degenerate
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [cs_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [cs_pkg::NORM_W-1:0]       a_ff, a_in;
   logic [cs_pkg::NORM_W-1:0]       b_ff, b_in;
   logic [cs_pkg::DOT_W-1:0]        mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic                            deg_ff, deg_in;
   logic [cs_pkg::PP_W-1:0]         pp_ff, pp_in;
   logic [1:0]                      sh_ff, sh_in;
   logic [cs_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [cs_pkg::ROOT_W-1:0]       root_ff, root_in;
   logic [cs_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [cs_pkg::NUM_W-1:0]        num_ff, num_in;
   logic [cs_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic                            ovf_ff, ovf_in;
   logic                            res_valid_ff, res_valid_in;
   logic [cs_pkg::OUT_W-1:0]        res_sim_ff, res_sim_in;
   logic                            res_deg_ff, res_deg_in;

   logic                            job_degen;
   logic [cs_pkg::HALF_LO_W-1:0]    mul_x;
   logic [cs_pkg::HALF_LO_W-1:0]    mul_y;
   logic [cs_pkg::PROD_W-1:0]       pp_shifted;
   logic [cs_pkg::REM_W-1:0]        sq_rem;
   logic [cs_pkg::REM_W-1:0]        sq_trial;
   logic                            sq_ge;
   logic [cs_pkg::ROOT_W-1:0]       divisor;
   logic [cs_pkg::ROOT_W:0]         dv_rem;
   logic                            dv_ge;
   logic [cs_pkg::QUO_W-1:0]        quo_neg;
   logic [cs_pkg::OUT_W-1:0]        sat_val;

   assign rsp_empty      = ~res_valid_ff;
   assign rsp_similarity = $signed(res_sim_ff);
   assign rsp_degenerate = res_deg_ff;

   // Shared datapath terms
   always_comb begin
      job_degen = job.mismatch || (job.left_norm == '0) || (job.right_norm == '0);

      // Norm product in four 21x21 partial products
      mul_x = step_ff[1] ? {1'b0, a_ff[cs_pkg::NORM_W-1:cs_pkg::HALF_LO_W]}
                         : a_ff[cs_pkg::HALF_LO_W-1:0];
      mul_y = step_ff[0] ? {1'b0, b_ff[cs_pkg::NORM_W-1:cs_pkg::HALF_LO_W]}
                         : b_ff[cs_pkg::HALF_LO_W-1:0];
      case (sh_ff)
         2'd0:    pp_shifted = {{(cs_pkg::PROD_W - cs_pkg::PP_W){1'b0}}, pp_ff};
         2'd1:    pp_shifted = {{(cs_pkg::PROD_W - cs_pkg::PP_W - cs_pkg::HALF_LO_W){1'b0}},
                                pp_ff, {cs_pkg::HALF_LO_W{1'b0}}};
         2'd2:    pp_shifted = {pp_ff, {(cs_pkg::PROD_W - cs_pkg::PP_W){1'b0}}};
         default: pp_shifted = '0;
      endcase

      // Restoring square root, two product bits per step
      sq_rem   = {rem_ff[cs_pkg::REM_W-3:0], prod_ff[cs_pkg::PROD_W-1:cs_pkg::PROD_W-2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge    = sq_rem >= sq_trial;

      // Restoring divide, one quotient bit per step
      divisor = (root_ff == '0) ? cs_pkg::ROOT_W'(1) : root_ff;
      dv_rem  = {rem_ff[cs_pkg::ROOT_W-1:0], num_ff[cs_pkg::NUM_W-1]};
      dv_ge   = dv_rem >= {1'b0, divisor};

      // Truncated quotient with its sign, clamped to the output range
      quo_neg = '0 - quo_ff;
      if (deg_ff) begin
         sat_val = '0;
      end else if (neg_ff) begin
         if (ovf_ff || quo_ff > cs_pkg::QUO_W'(32768)) begin
            sat_val = cs_pkg::SIM_MIN;
         end else begin
            sat_val = quo_neg[cs_pkg::OUT_W-1:0];
         end
      end else begin
         if (ovf_ff || quo_ff > cs_pkg::QUO_W'(32767)) begin
            sat_val = cs_pkg::SIM_MAX;
         end else begin
            sat_val = quo_ff[cs_pkg::OUT_W-1:0];
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      deg_in       = deg_ff;
      pp_in        = pp_ff;
      sh_in        = sh_ff;
      prod_in      = prod_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      res_sim_in   = res_sim_ff;
      res_deg_in   = res_deg_ff;
      res_valid_in = res_valid_ff & ~rsp_pop;
      job_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               job_pop = 1'b1;
               a_in    = job.left_norm;
               b_in    = job.right_norm;
               neg_in  = job.dot[cs_pkg::DOT_W-1];
               mag_in  = job.dot[cs_pkg::DOT_W-1] ? ('0 - job.dot) : job.dot;
               deg_in  = job_degen;
               step_in = '0;
               prod_in = '0;
               quo_in  = '0;
               ovf_in  = 1'b0;
               state_in = job_degen ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            pp_in = {{(cs_pkg::PP_W - cs_pkg::HALF_LO_W){1'b0}}, mul_x} *
                    {{(cs_pkg::PP_W - cs_pkg::HALF_LO_W){1'b0}}, mul_y};
            sh_in = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            if (step_ff != '0) begin
               prod_in = prod_ff + pp_shifted;
            end
            if (step_ff == cs_pkg::STEP_W'(cs_pkg::MUL_STEPS)) begin
               step_in  = '0;
               root_in  = '0;
               rem_in   = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            prod_in = {prod_ff[cs_pkg::PROD_W-3:0], 2'b00};
            root_in = {root_ff[cs_pkg::ROOT_W-2:0], sq_ge};
            rem_in  = sq_ge ? (sq_rem - sq_trial) : sq_rem;
            if (step_ff == cs_pkg::STEP_W'(cs_pkg::SQRT_STEPS - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               num_in   = {mag_ff, {cs_pkg::FRAC_W{1'b0}}};
               quo_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            rem_in = {{(cs_pkg::REM_W - cs_pkg::ROOT_W - 1){1'b0}},
                      dv_ge ? (dv_rem - {1'b0, divisor}) : dv_rem};
            quo_in = {quo_ff[cs_pkg::QUO_W-2:0], dv_ge};
            ovf_in = ovf_ff | quo_ff[cs_pkg::QUO_W-1];
            num_in = {num_ff[cs_pkg::NUM_W-2:0], 1'b0};
            if (step_ff == cs_pkg::STEP_W'(cs_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!res_valid_ff || rsp_pop) begin
               res_valid_in = 1'b1;
               res_sim_in   = sat_val;
               res_deg_in   = deg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         res_valid_ff <= res_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      deg_ff     <= deg_in;
      pp_ff      <= pp_in;
      sh_ff      <= sh_in;
      prod_ff    <= prod_in;
      root_ff    <= root_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
      res_sim_ff <= res_sim_in;
      res_deg_ff <= res_deg_in;
   end

`ifndef SYNTHESIS
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (root_ff[cs_pkg::ROOT_W-1] == 1'b0))
      else $error("square root exceeds 41 bits");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_deg_ff) |-> (res_sim_ff == '0))
      else $error("degenerate item with nonzero similarity");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_cosine_similarity_top.sv
// Self-checking testbench for the streaming cosine similarity block.
`timescale 1ns / 1ps
`default_nettype none
module tb_cosine_similarity_top;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_PAIRS  = 650;
   localparam int DRAIN_CYCLES  = 150;
   localparam logic signed [cs_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
   localparam logic signed [cs_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;

   // Shape of a random vector's right side
   typedef enum int {SHAPE_FREE, SHAPE_SAME, SHAPE_NEGATED} vec_shape_type;
   // Which side of a random vector is forced to zero
   typedef enum int {ZERO_NONE, ZERO_LEFT, ZERO_RIGHT} zero_side_type;

   typedef struct {
      logic signed [cs_pkg::OUT_W-1:0] similarity;
      logic                            degenerate;
   } sim_result_type;

   // Tracks the running sums and holds the similarities still owed by the block
   class similarity_tracker_type;
      logic signed [cs_pkg::DOT_W-1:0] dot_acc;
      logic [cs_pkg::NORM_W-1:0]       left_norm_acc;
      logic [cs_pkg::NORM_W-1:0]       right_norm_acc;
      logic                            mismatch_acc;
      sim_result_type                  owed_results[$];
      int unsigned                     n_errors;

      function new();
         dot_acc        = '0;
         left_norm_acc  = '0;
         right_norm_acc = '0;
         mismatch_acc   = 1'b0;
         n_errors       = 0;
      endfunction

      // Floor square root of an 82-bit product, one result bit per step
      function logic [cs_pkg::ROOT_W-1:0] floor_root(
            input logic [2*cs_pkg::NORM_W-1:0] prod);
         logic [cs_pkg::ROOT_W-1:0]   root;
         logic [cs_pkg::ROOT_W-1:0]   trial;
         logic [2*cs_pkg::ROOT_W-1:0] trial_sq;
         root = '0;
         for (int b = cs_pkg::ROOT_W - 1; b >= 0; b--) begin
            trial    = root | (cs_pkg::ROOT_W'(1) << b);
            trial_sq = {{cs_pkg::ROOT_W{1'b0}}, trial} * {{cs_pkg::ROOT_W{1'b0}}, trial};
            if (trial_sq <= {2'b00, prod})
               root = trial;
         end
         return root;
      endfunction

      // One accepted element pair; a last pair closes the vector
      function void accumulate_pair(input logic signed [cs_pkg::ELEM_W-1:0] lv,
                                    input logic signed [cs_pkg::ELEM_W-1:0] rv,
                                    input logic is_last, input logic mm);
         logic signed [cs_pkg::DPROD_W-1:0] dprod;
         logic signed [cs_pkg::DPROD_W-1:0] lsq;
         logic signed [cs_pkg::DPROD_W-1:0] rsq;
         logic [cs_pkg::ROOT_W-1:0]         root;
         longint                            num;
         longint                            den;
         longint                            quo;
         sim_result_type                    res;
         dprod = lv * rv;
         lsq   = lv * lv;
         rsq   = rv * rv;
         dot_acc        = dot_acc +
                          {{(cs_pkg::DOT_W-cs_pkg::DPROD_W){dprod[cs_pkg::DPROD_W-1]}}, dprod};
         left_norm_acc  = left_norm_acc + {{(cs_pkg::NORM_W-cs_pkg::DPROD_W){1'b0}}, lsq};
         right_norm_acc = right_norm_acc + {{(cs_pkg::NORM_W-cs_pkg::DPROD_W){1'b0}}, rsq};
         if (mm)
            mismatch_acc = 1'b1;
         if (!is_last)
            return;
         res.degenerate = mismatch_acc || left_norm_acc == '0 || right_norm_acc == '0;
         res.similarity = '0;
         if (!res.degenerate) begin
            root = floor_root({{cs_pkg::NORM_W{1'b0}}, left_norm_acc} *
                              {{cs_pkg::NORM_W{1'b0}}, right_norm_acc});
            if (root == '0)
               root = cs_pkg::ROOT_W'(1);
            num = longint'(dot_acc) * 32768;
            den = longint'({22'd0, root});
            quo = num / den;
            if (quo > 32767)
               quo = 32767;
            if (quo < -32768)
               quo = -32768;
            res.similarity = quo[cs_pkg::OUT_W-1:0];
         end
         owed_results.insert(owed_results.size(), res);
         dot_acc        = '0;
         left_norm_acc  = '0;
         right_norm_acc = '0;
         mismatch_acc   = 1'b0;
      endfunction

      // Compare a popped result with the oldest owed one
      function void check_similarity(input logic signed [cs_pkg::OUT_W-1:0] sim,
                                     input logic degen);
         sim_result_type want;
         if (owed_results.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("ERROR: unexpected result similarity=%0d degenerate=%b",
                        sim, degen);
            return;
         end
         want = owed_results.pop_front();
         if (sim !== want.similarity || degen !== want.degenerate) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("ERROR: similarity exp %0d got %0d, degenerate exp %b got %b",
                        want.similarity, sim, want.degenerate, degen);
         end
      endfunction

      function int owed();
         return owed_results.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset           = 1'b1;
   logic                             req_push        = 1'b0;
   logic                             req_full;
   logic signed [cs_pkg::ELEM_W-1:0] req_left_value  = '0;
   logic signed [cs_pkg::ELEM_W-1:0] req_right_value = '0;
   logic                             req_last        = 1'b0;
   logic                             req_mismatch    = 1'b0;
   logic                             rsp_empty;
   logic                             rsp_pop         = 1'b0;
   logic signed [cs_pkg::OUT_W-1:0]  rsp_similarity;
   logic                             rsp_degenerate;

   similarity_tracker_type tracker;
   int                burst_left;
   int                pairs_sent;
   int                pop_pct    = 100;
   int                pop_left   = 0;
   int                cycle_count = 0;

   cosine_similarity_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_left_value  (req_left_value),
      .req_right_value (req_right_value),
      .req_last        (req_last),
      .req_mismatch    (req_mismatch),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_similarity  (rsp_similarity),
      .rsp_degenerate  (rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cosine_similarity_top test failed");
         $finish;
      end
   end

   // Receiver: check popped items, pop rate changes every stretch
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         tracker.check_similarity(rsp_similarity, rsp_degenerate);
      if (pop_left == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    pop_pct <= 100;
            2:       pop_pct <= 60;
            3:       pop_pct <= 25;
            default: pop_pct <= 8;
         endcase
         pop_left <= $urandom_range(20, 200);
      end else begin
         pop_left <= pop_left - 1;
      end
      rsp_pop <= ($urandom_range(1, 100) <= pop_pct);
   end

   // Drop push for a number of cycles
   task automatic hold_off(input int n);
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one pair and wait until the block takes it
   task automatic push_pair(input logic signed [cs_pkg::ELEM_W-1:0] lv,
                            input logic signed [cs_pkg::ELEM_W-1:0] rv,
                            input logic is_last, input logic mm);
      if (burst_left == 0) begin
         hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9));
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
      end
      burst_left--;
      req_push        <= 1'b1;
      req_left_value  <= lv;
      req_right_value <= rv;
      req_last        <= is_last;
      req_mismatch    <= mm;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tracker.accumulate_pair(lv, rv, is_last, mm);
      pairs_sent++;
   endtask

   // Element value biased toward extremes and small magnitudes
   function automatic logic signed [cs_pkg::ELEM_W-1:0] pick_value();
      logic signed [cs_pkg::ELEM_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = ELEM_MAX;
         1:       v = ELEM_MIN;
         2:       v = cs_pkg::ELEM_W'($signed($urandom_range(0, 8)) - 4);
         3:       v = '0;
         default: v = cs_pkg::ELEM_W'($urandom());
      endcase
      return v;
   endfunction

   // One random vector; mm_at < 0 means no mismatch flag
   task automatic send_vector(input int len, input int mm_at,
                              input zero_side_type zside, input vec_shape_type shape);
      logic signed [cs_pkg::ELEM_W-1:0] lv;
      logic signed [cs_pkg::ELEM_W-1:0] rv;
      for (int k = 0; k < len; k++) begin
         lv = pick_value();
         case (shape)
            SHAPE_SAME:    rv = lv;
            SHAPE_NEGATED: rv = -lv;
            default:       rv = pick_value();
         endcase
         if (zside == ZERO_LEFT)
            lv = '0;
         if (zside == ZERO_RIGHT)
            rv = '0;
         push_pair(lv, rv, k == len - 1, k == mm_at);
      end
   endtask

   // Stimulus
   initial begin
      int            len;
      int            mm_at;
      zero_side_type zside;
      vec_shape_type shape;
      tracker       = new();
      burst_left    = 0;
      pairs_sent    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, both output limits, zero norms, mismatch flags
      push_pair(ELEM_MAX, ELEM_MAX, 1'b1, 1'b0);
      push_pair(ELEM_MIN, ELEM_MIN, 1'b1, 1'b0);
      push_pair(ELEM_MIN, ELEM_MAX, 1'b1, 1'b0);
      push_pair(ELEM_MAX, ELEM_MIN, 1'b1, 1'b0);
      push_pair(16'sd1, ELEM_MAX, 1'b1, 1'b0);
      push_pair(16'sd0, 16'sd1234, 1'b1, 1'b0);
      push_pair(-16'sd5, 16'sd0, 1'b1, 1'b0);
      push_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
      push_pair(16'sd100, 16'sd200, 1'b0, 1'b0);
      push_pair(-16'sd300, 16'sd400, 1'b0, 1'b0);
      push_pair(ELEM_MAX, -16'sd1, 1'b1, 1'b0);
      push_pair(16'sd1, 16'sd1, 1'b0, 1'b0);
      push_pair(16'sd2, 16'sd2, 1'b0, 1'b1);
      push_pair(16'sd3, 16'sd3, 1'b1, 1'b0);
      push_pair(16'sd7, 16'sd9, 1'b0, 1'b0);
      push_pair(16'sd8, -16'sd9, 1'b1, 1'b1);
      push_pair(16'sd1, -16'sd1, 1'b1, 1'b0);
      push_pair(16'sd1, 16'sd0, 1'b0, 1'b0);
      push_pair(16'sd0, 16'sd1, 1'b1, 1'b0);
      push_pair(-16'sd21846, 16'sd10923, 1'b0, 1'b0);
      push_pair(16'sh5555, -16'sh2AAA, 1'b1, 1'b0);

      // Let the block drain completely before the random part
      hold_off(1);
      while (tracker.owed() != 0) @(posedge clock);

      // Random vectors, mostly short
      pairs_sent = 0;
      while (pairs_sent < RANDOM_PAIRS) begin
         case ($urandom_range(0, 19))
            0:       len = $urandom_range(41, 120);
            1, 2, 3,
            4, 5:    len = $urandom_range(7, 40);
            default: len = $urandom_range(1, 6);
         endcase
         mm_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, len - 1) : -1;
         case ($urandom_range(0, 19))
            0:       zside = ZERO_LEFT;
            1:       zside = ZERO_RIGHT;
            default: zside = ZERO_NONE;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2: shape = SHAPE_SAME;
            3:       shape = SHAPE_NEGATED;
            default: shape = SHAPE_FREE;
         endcase
         send_vector(len, mm_at, zside, shape);
      end
      hold_off(1);

      // Wait for every owed result, then let the back end settle
      while (tracker.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.n_errors == 0 && tracker.owed() == 0) begin
         $display("cosine_similarity_top test passed");
      end else begin
         $display("cosine_similarity_top test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
